// ----- rtl/core/dtlc_pkg.sv -----
package dtlc_pkg;

  localparam int ID_BITS     = 16;
  localparam int SLOT_BITS   = 6;
  localparam int STATUS_BITS = 3;
  localparam int ROOT_BITS   = 15;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_LINK  = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_BAD_PARAM = 3'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_SELF_LINK = 3'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] STATUS_TYPE      = 3'd4;
  localparam logic [STATUS_BITS-1:0] STATUS_CYCLE     = 3'd5;
  localparam logic [STATUS_BITS-1:0] STATUS_BROKEN    = 3'd6;

  // configuration register indexes
  localparam logic REG_ROOT_ID = 1'b0;

  typedef struct packed {
    logic                        operation;
    logic [SLOT_BITS-1:0]        slot;
    logic                        entry_valid;
    logic                        entry_is_control;
    logic signed [ID_BITS-1:0]   dev_id;
    logic signed [ID_BITS-1:0]   host_id;
  } dtlc_in_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic                   changed;
    logic [SLOT_BITS-1:0]   changed_slot;
  } dtlc_out_t;

  // one table entry as held in the node memory
  typedef struct packed {
    logic               valid;
    logic               is_control;
    logic [ID_BITS-1:0] id;
    logic [ID_BITS-1:0] parent;
  } dtlc_node_t;

  typedef enum logic [1:0] {
    LK_CHILD,
    LK_PARENT,
    LK_WALK
  } dtlc_purpose_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WALK
  } dtlc_state_t;

endpackage

// ----- rtl/core/device_tree_link_checker.sv -----
// channel   | ports                                  | handshake
// ----------+----------------------------------------+------------------------------------
// item in   | start, busy, request (dtlc_in_t)       | taken at an edge with start & !busy
// result    | done, result (dtlc_out_t)              | one cycle per done pulse, no stall
// config    | psel penable pwrite paddr pwdata       | written on psel & penable & pwrite
//           | prdata pready                          | pready tied high, root_id at 0
//
// a write item is handled in the idle state; its result shows on the next cycle
// a link item scans the node memory one slot per cycle (registered read data); the
// child lookup, parent lookup and up to TABLE_DEPTH+1 ancestor lookups are done one
// after another
// after reset a clearing pass zeroes every slot of the memory with busy high
// the receiver cannot stall: result is valid only while done is high
module device_tree_link_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dtlc_pkg::dtlc_in_t  request,
  output logic                done,
  output dtlc_pkg::dtlc_out_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import dtlc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);     // slot index bits
  localparam int CW = AW + 1;                  // scan counter, reaches TABLE_DEPTH
  localparam int SW = $clog2(TABLE_DEPTH + 2); // walk step counter, reaches depth + 1

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(TABLE_DEPTH - 1);
  localparam logic [SW-1:0] STEPS_C = SW'(TABLE_DEPTH);

  // node table memory, one read port with registered data and one write port
  dtlc_node_t mem [TABLE_DEPTH];
  dtlc_node_t rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  dtlc_node_t    mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  // configuration register
  logic [ROOT_BITS-1:0] root_id;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_id <= '0;
    end else if (cfg_write && paddr[2] == REG_ROOT_ID) begin
      root_id <= pwdata[ROOT_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ROOT_ID) begin
      prdata = 32'(root_id);
    end
  end

  // root id as a table id, always non-negative
  logic [ID_BITS-1:0] root_ext;
  assign root_ext = ID_BITS'(root_id);

  // sequencer registers
  dtlc_state_t        state, state_next;
  dtlc_purpose_t      purpose, purpose_next;
  logic [CW-1:0]      scan_idx, scan_idx_next;   // next slot to read, also clear pointer
  logic               chk_vld, chk_vld_next;     // rd_data holds a slot under test
  logic [AW-1:0]      chk_idx, chk_idx_next;     // slot that rd_data came from
  logic [ID_BITS-1:0] key, key_next;             // id being looked up
  logic [ID_BITS-1:0] child, child_next;
  logic [ID_BITS-1:0] parent, parent_next;
  logic [ID_BITS-1:0] cur, cur_next;             // walk position
  logic [SW-1:0]      steps, steps_next;
  logic [AW-1:0]      ci, ci_next;               // child's slot
  dtlc_node_t         ci_node, ci_node_next;     // child's entry for write-back
  dtlc_out_t          result_next;
  logic               done_next;

  logic hit;
  logic miss_end;
  logic issue;
  logic slot_ok;

  assign hit      = chk_vld && rd_data.valid && (rd_data.id == key);
  assign miss_end = chk_vld && !hit && (chk_idx == LAST_C);
  assign issue    = scan_idx < DEPTH_C;
  assign slot_ok  = 32'(request.slot) < 32'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      scan_idx <= '0;
      chk_vld  <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      chk_vld  <= chk_vld_next;
      done     <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    purpose <= purpose_next;
    chk_idx <= chk_idx_next;
    key     <= key_next;
    child   <= child_next;
    parent  <= parent_next;
    cur     <= cur_next;
    steps   <= steps_next;
    ci      <= ci_next;
    ci_node <= ci_node_next;
    result  <= result_next;
  end

  always_comb begin
    state_next    = state;
    purpose_next  = purpose;
    scan_idx_next = scan_idx;
    chk_vld_next  = 1'b0;
    chk_idx_next  = scan_idx[AW-1:0];
    key_next      = key;
    child_next    = child;
    parent_next   = parent;
    cur_next      = cur;
    steps_next    = steps;
    ci_next       = ci;
    ci_node_next  = ci_node;
    result_next   = result;
    done_next     = 1'b0;
    rd_addr       = scan_idx[AW-1:0];
    mem_we        = 1'b0;
    mem_wa        = scan_idx[AW-1:0];
    mem_wd        = '0;

    case (state)
      ST_CLEAR: begin
        // zero one slot a cycle so every valid mark starts cleared
        mem_we = 1'b1;
        if (scan_idx[AW-1:0] == LAST_C) begin
          scan_idx_next = '0;
          state_next    = ST_IDLE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (request.operation == OP_WRITE) begin
            // table load, done in place
            done_next   = 1'b1;
            result_next = '{status: STATUS_OK, changed: 1'b0, changed_slot: '0};
            if (slot_ok) begin
              mem_we                   = 1'b1;
              mem_wa                   = AW'(request.slot);
              mem_wd.valid             = request.entry_valid;
              mem_wd.is_control        = request.entry_is_control;
              mem_wd.id                = request.dev_id;
              mem_wd.parent            = request.host_id;
              result_next.changed      = 1'b1;
              result_next.changed_slot = request.slot;
            end
          end else begin
            child_next  = request.dev_id;
            parent_next = request.host_id;
            result_next = '{status: STATUS_OK, changed: 1'b0, changed_slot: '0};
            if (request.dev_id[ID_BITS-1] || request.host_id[ID_BITS-1]) begin
              done_next          = 1'b1;
              result_next.status = STATUS_BAD_PARAM;
            end else if (request.dev_id == request.host_id) begin
              done_next          = 1'b1;
              result_next.status = STATUS_SELF_LINK;
            end else begin
              key_next      = request.dev_id;
              purpose_next  = LK_CHILD;
              scan_idx_next = '0;
              state_next    = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          scan_idx_next = '0;
          case (purpose)
            LK_CHILD: begin
              ci_next      = chk_idx;
              ci_node_next = rd_data;
              if (parent == root_ext) begin
                // root is always a valid parent: link at once
                mem_we        = 1'b1;
                mem_wa        = chk_idx;
                mem_wd        = rd_data;
                mem_wd.parent = parent;
                result_next   = '{status: STATUS_OK, changed: 1'b1,
                                  changed_slot: SLOT_BITS'(chk_idx)};
                done_next     = 1'b1;
                state_next    = ST_IDLE;
              end else begin
                key_next     = parent;
                purpose_next = LK_PARENT;
              end
            end
            LK_PARENT: begin
              if (!rd_data.is_control) begin
                result_next.status = STATUS_TYPE;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
              end else begin
                cur_next   = parent;
                steps_next = '0;
                state_next = ST_WALK;
              end
            end
            LK_WALK: begin
              cur_next   = rd_data.parent;
              steps_next = steps + 1'b1;
              if (steps + 1'b1 > STEPS_C) begin
                result_next.status = STATUS_CYCLE;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
              end else begin
                state_next = ST_WALK;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end else if (miss_end) begin
          scan_idx_next      = '0;
          result_next.status = (purpose == LK_WALK) ? STATUS_BROKEN : STATUS_NOT_FOUND;
          done_next          = 1'b1;
          state_next         = ST_IDLE;
        end else begin
          // keep one read in flight per cycle
          chk_vld_next = issue;
          if (issue) begin
            scan_idx_next = scan_idx + 1'b1;
          end
        end
      end

      ST_WALK: begin
        if (cur == child) begin
          result_next.status = STATUS_CYCLE;
          done_next          = 1'b1;
          state_next         = ST_IDLE;
        end else if (cur == root_ext) begin
          // chain reaches root: commit the new parent
          mem_we        = 1'b1;
          mem_wa        = ci;
          mem_wd        = ci_node;
          mem_wd.parent = parent;
          result_next   = '{status: STATUS_OK, changed: 1'b1,
                            changed_slot: SLOT_BITS'(ci)};
          done_next     = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          key_next      = cur;
          purpose_next  = LK_WALK;
          scan_idx_next = '0;
          state_next    = ST_SCAN;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // a result only follows an accepted item or the end of a link sequence
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without an item");

  // a failed item never reports a table change
  assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STATUS_OK) |-> (!result.changed && result.changed_slot == '0))
    else $error("failed item reports a change");

  // a slot under test only exists while scanning
  assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> (state == ST_SCAN))
    else $error("lookup data outside a scan");

  // clearing pass holds off items right after reset
  assert property (@(posedge clk)
    (!rst && $past(rst)) |-> busy)
    else $error("idle during clearing pass");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import dtlc_pkg::*;

  localparam int DEPTH        = 64;
  localparam int POOL_SIZE    = 12;
  localparam int PHASES       = 4;
  localparam int RANDOM_ITEMS = 132;
  // a link may scan the table for the child, the parent and up to DEPTH+1 ancestors
  localparam int WORST_LINK   = (DEPTH + 3) * (DEPTH + 1);
  localparam int STALL_LIMIT  = 5 * WORST_LINK;
  localparam int TAIL_CYCLES  = WORST_LINK;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  dtlc_in_t            request = '0;
  logic                done;
  dtlc_out_t           result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // items waiting for the driver, and outcomes waiting for the block
  dtlc_in_t            pending_items[$];
  dtlc_out_t           expected_outcomes[$];

  // shadow of the node table and of the root register
  bit                  node_ok[DEPTH];
  bit                  node_ctrl[DEPTH];
  int                  node_key[DEPTH];
  int                  node_up[DEPTH];
  logic [ROOT_BITS-1:0] root_setting = '0;

  int                  id_pool[POOL_SIZE];
  int                  idle_pct = 0;
  int                  mismatch_count = 0;
  int                  stall_cycles = 0;

  device_tree_link_checker #(.TABLE_DEPTH(DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // lowest valid slot holding the id, -1 if none
  function automatic int find_node(input int id);
    for (int i = 0; i < DEPTH; i++)
      if (node_ok[i] && node_key[i] == id)
        return i;
    return -1;
  endfunction

  // applies one item to the shadow table and returns what the block should answer
  function automatic dtlc_out_t predict_outcome(input dtlc_in_t item);
    dtlc_out_t res;
    int        child;
    int        parent;
    int        root;
    int        ci;
    int        pi;
    int        k;
    int        cur;
    int        hops;
    bit        walking;
    res    = '0;
    child  = $signed(item.dev_id);
    parent = $signed(item.host_id);
    root   = int'(root_setting);
    if (item.operation == OP_WRITE) begin
      // a cleared entry still reports the slot as changed
      node_ok[item.slot]   = item.entry_valid;
      node_ctrl[item.slot] = item.entry_is_control;
      node_key[item.slot]  = child;
      node_up[item.slot]   = parent;
      res.changed          = 1'b1;
      res.changed_slot     = item.slot;
      return res;
    end
    res.status = STATUS_OK;
    if (child < 0 || parent < 0) begin
      res.status = STATUS_BAD_PARAM;
    end else if (child == parent) begin
      res.status = STATUS_SELF_LINK;
    end else begin
      ci = find_node(child);
      if (ci < 0) begin
        res.status = STATUS_NOT_FOUND;
      end else if (parent != root) begin
        // root needs no slot; anything else must exist and take children
        pi = find_node(parent);
        if (pi < 0) begin
          res.status = STATUS_NOT_FOUND;
        end else if (!node_ctrl[pi]) begin
          res.status = STATUS_TYPE;
        end else begin
          // climb from the parent until the root, the child or a dead end
          cur     = parent;
          hops    = 0;
          walking = 1'b1;
          while (walking) begin
            if (cur == child) begin
              res.status = STATUS_CYCLE;
              walking    = 1'b0;
            end else if (cur == root) begin
              walking = 1'b0;
            end else begin
              k = find_node(cur);
              if (k < 0) begin
                res.status = STATUS_BROKEN;
                walking    = 1'b0;
              end else begin
                cur = node_up[k];
                hops++;
                // loop that never reaches the child
                if (hops > DEPTH) begin
                  res.status = STATUS_CYCLE;
                  walking    = 1'b0;
                end
              end
            end
          end
        end
      end
      if (ci >= 0 && res.status == STATUS_OK) begin
        node_up[ci]      = parent;
        res.changed      = 1'b1;
        res.changed_slot = ci[SLOT_BITS-1:0];
      end
    end
    return res;
  endfunction

  task automatic queue_write(input int slot, input bit valid, input bit ctrl,
                             input int id, input int parent);
    dtlc_in_t item;
    item                  = '0;
    item.operation        = OP_WRITE;
    item.slot             = slot[SLOT_BITS-1:0];
    item.entry_valid      = valid;
    item.entry_is_control = ctrl;
    item.dev_id           = id[ID_BITS-1:0];
    item.host_id          = parent[ID_BITS-1:0];
    pending_items.push_back(item);
  endtask

  task automatic queue_link(input int child, input int parent);
    dtlc_in_t item;
    item           = '0;
    item.operation = OP_LINK;
    item.slot      = SLOT_BITS'($urandom);
    item.dev_id    = child[ID_BITS-1:0];
    item.host_id   = parent[ID_BITS-1:0];
    pending_items.push_back(item);
  endtask

  // mostly writes and links over a small id pool so that chains form, some noise
  function automatic dtlc_in_t random_item();
    dtlc_in_t     item;
    logic [63:0]  raw;
    int           pick;
    pick = $urandom_range(99);
    raw  = {$urandom, $urandom};
    item = raw[$bits(dtlc_in_t)-1:0];
    if (pick < 45) begin
      item.operation        = OP_WRITE;
      item.entry_valid      = ($urandom_range(9) != 0);
      item.entry_is_control = ($urandom_range(9) < 6);
      item.dev_id           = id_pool[$urandom_range(POOL_SIZE-1)][ID_BITS-1:0];
      item.host_id          = ($urandom_range(99) < 55) ? id_pool[0][ID_BITS-1:0]
                              : id_pool[$urandom_range(POOL_SIZE-1)][ID_BITS-1:0];
    end else if (pick < 92) begin
      item.operation = OP_LINK;
      item.dev_id    = id_pool[$urandom_range(POOL_SIZE-1)][ID_BITS-1:0];
      item.host_id   = ($urandom_range(99) < 30) ? id_pool[0][ID_BITS-1:0]
                       : id_pool[$urandom_range(POOL_SIZE-1)][ID_BITS-1:0];
    end
    return item;
  endfunction

  // apb write of root_id followed by a read back
  task automatic set_root(input logic [ROOT_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ROOT_ID, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    root_setting = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[ROOT_BITS-1:0] !== value)
      flag_mismatch($sformatf("root_id read %0h, wrote %0h", prdata[ROOT_BITS-1:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // driver: predicts each accepted item, then offers the next one or idles
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_outcomes.push_back(predict_outcome(request));
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          request <= pending_items.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done pulse is matched against the oldest outcome
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: %p", result));
      end else begin : compare_fields
        dtlc_out_t want;
        want = expected_outcomes.pop_front();
        if (result.status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", result.status, want.status));
        if (result.changed !== want.changed)
          flag_mismatch($sformatf("changed %0b, expected %0b", result.changed, want.changed));
        if (result.changed_slot !== want.changed_slot)
          flag_mismatch($sformatf("changed_slot %0d, expected %0d",
                                  result.changed_slot, want.changed_slot));
      end
    end
  end

  // watchdog: too long with no item, result or register access means a hang
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", stall_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [ROOT_BITS-1:0] phase_root[PHASES];
    int                   phase_idle[PHASES];
    phase_root[0] = '0;
    phase_root[1] = '1;
    phase_root[2] = ROOT_BITS'($urandom);
    phase_root[3] = 15'd3;
    phase_idle[0] = 0;
    phase_idle[1] = 52;
    phase_idle[2] = 11;
    phase_idle[3] = 0;
    foreach (node_ok[i]) begin
      node_ok[i]   = 1'b0;
      node_ctrl[i] = 1'b0;
      node_key[i]  = 0;
      node_up[i]   = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      // block idle: clearing pass over, all items answered
      do @(posedge clk);
      while (busy || start || pending_items.size() > 0 || expected_outcomes.size() > 0);
      repeat (4) @(posedge clk);
      set_root(phase_root[p]);
      @(negedge clk);
      idle_pct   = phase_idle[p];
      id_pool[0] = int'(phase_root[p]);
      for (int i = 1; i < POOL_SIZE; i++)
        id_pool[i] = (i % 2) ? $urandom_range(32767) : ((int'(phase_root[p]) + i) & 32'h7fff);

      if (p == 0) begin
        // directed part, root id is 0 here
        queue_write(0, 1, 1, 10, 0);
        queue_write(63, 1, 0, 32767, -32768);
        queue_write(1, 1, 1, 20, 10);
        queue_write(2, 1, 0, 30, 20);
        queue_link(-32768, 10);        // negative child
        queue_link(10, -1);            // negative parent
        queue_link(20, 20);            // self link
        queue_link(99, 10);            // child missing
        queue_link(30, 0);             // straight to root
        queue_link(30, 77);            // parent missing
        queue_link(10, 30);            // parent cannot take children
        queue_link(10, 20);            // ancestor walk meets the child
        queue_write(3, 1, 1, 40, 555);
        queue_link(30, 40);            // chain ends in an unknown id
        queue_write(4, 1, 1, 50, 60);
        queue_write(5, 1, 1, 60, 50);
        queue_link(30, 50);            // loop without the child, walk runs out of steps
        queue_link(30, 20);            // good link two levels down
        queue_write(6, 1, 0, 20, 0);
        queue_link(32767, 20);         // duplicate id, lowest slot wins
        queue_write(1, 0, 1, 20, 10);  // clearing a slot uncovers the duplicate
        queue_link(30, 20);
        queue_link(10, 32767);
        queue_link(32767, 32766);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++)
        pending_items.push_back(random_item());
    end

    do @(posedge clk);
    while (start || pending_items.size() > 0 || expected_outcomes.size() > 0);
    // late or extra results would show up here
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_outcomes.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dtlc_pkg.sv
rtl/core/device_tree_link_checker.sv
verif/testbench.sv
